/* sv/adpcm_block_decoder_two_tap_defines.svh */
// Assertion macros shared by the two-tap ADPCM decoder RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ADPCM_BLOCK_DECODER_TWO_TAP_DEFINES_SVH
`define ADPCM_BLOCK_DECODER_TWO_TAP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is active.
`define ADPCM2T_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adpcm2t: assertion failed");
// Next-cycle implication, disabled while reset is active.
`define ADPCM2T_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adpcm2t: assertion failed");
`else
`define ADPCM2T_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ADPCM2T_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* sv/adpcm2t_pkg.sv */
// Package for the two-tap ADPCM decoder: types, constants and codes.
// Depends on nothing; used by the top level and the multiply-accumulate unit.
`default_nettype none

package adpcm2t_pkg;

    // Default sizing of the decoder.
    localparam int FRAME_BYTES_DEF = 18;
    localparam int CHANNELS_DEF    = 2;

    // Arithmetic sizing.
    localparam int OPND_W     = 17;
    localparam int ACC_W      = 40;
    localparam int GAIN_SHIFT = 13;
    localparam int FRAC_SHIFT = 13;
    localparam int PCM_MAX    = 32767;
    localparam int PCM_MIN    = -32768;

    // Register reset values.
    localparam logic signed [15:0] COEF_FIRST_RESET  = 16'sd14668;
    localparam logic signed [15:0] COEF_SECOND_RESET = -16'sd6566;

    // Configuration register indexes.
    localparam logic CFG_COEF_FIRST  = 1'b0;
    localparam logic CFG_COEF_SECOND = 1'b1;

    // Input operation codes.
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_CLIP
    } t_state;

    // Controls from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic mul_en;
        logic shift;
        logic acc_clr;
        logic acc_add;
    } t_mac_ctl;

endpackage

`default_nettype wire

/* sv/adpcm2t_mac.sv */
// Shared multiply-accumulate unit with floor shift and 16-bit clipping.
// Depends on adpcm2t_pkg for widths, constants and the control struct.
`default_nettype none

module adpcm2t_mac (
    input  wire                                         i_clk,
    input  wire adpcm2t_pkg::t_mac_ctl                  i_ctl,
    input  wire logic signed [adpcm2t_pkg::OPND_W-1:0]  i_op_a,
    input  wire logic signed [adpcm2t_pkg::OPND_W-1:0]  i_op_b,
    output logic signed [15:0]                          o_sample
);

    localparam int ACC_W = adpcm2t_pkg::ACC_W;
    localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(adpcm2t_pkg::PCM_MAX);
    localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(adpcm2t_pkg::PCM_MIN);

    logic signed [2*adpcm2t_pkg::OPND_W-1:0] w_mult;
    logic signed [ACC_W-1:0] w_prod_ext;
    logic signed [ACC_W-1:0] w_prod_sh;
    logic signed [ACC_W-1:0] w_q;
    logic signed [ACC_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;

    // One signed product per cycle; the nibble term is scaled by the gain shift.
    always_comb begin
        w_mult     = i_op_a * i_op_b;
        w_prod_ext = ACC_W'(w_mult);
        w_prod_sh  = i_ctl.shift ? (w_prod_ext <<< adpcm2t_pkg::GAIN_SHIFT) : w_prod_ext;
    end

    // Product register, then accumulation of the registered product.
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= w_prod_sh;
        end
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // Arithmetic shift gives the floor quotient; then saturate to 16 bits.
    always_comb begin
        w_q = r_acc >>> adpcm2t_pkg::FRAC_SHIFT;
        if (w_q > Q_MAX) begin
            o_sample = Q_MAX[15:0];
        end else if (w_q < Q_MIN) begin
            o_sample = Q_MIN[15:0];
        end else begin
            o_sample = w_q[15:0];
        end
    end

endmodule

`default_nettype wire

/* sv/adpcm_block_decoder_two_tap.sv */
// Two-tap block ADPCM decoder. Each frame of FRAME_BYTES bytes per channel starts
// with two scale bytes (high byte first); every later byte yields two samples,
// high nibble first, each predicted from the channel's last two samples with the
// coef_first and coef_second weights (Q13) and clipped to 16 bits. A clear
// transaction zeroes scale and history of all channels. Scale bytes, clear
// transactions and ignored bytes do not start the sequencer. For a data byte, each
// nibble passes the single 17x17 multiplier in product steps for the scaled
// nibble and both history terms, then an accumulate and a clip-and-output step;
// the block is ready again in the cycle after the second sample. If the output
// register is still full when a sample is due, the sequencer waits until it is taken.
// Depends on adpcm2t_pkg, adpcm2t_mac and the assertion macro header.
`default_nettype none
`include "adpcm_block_decoder_two_tap_defines.svh"

module adpcm_block_decoder_two_tap #(
    parameter int FRAME_BYTES = adpcm2t_pkg::FRAME_BYTES_DEF,
    parameter int CHANNELS    = adpcm2t_pkg::CHANNELS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    // Configuration write channel.
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire  [0:0]        i_cfg_index,
    input  wire  [15:0]       i_cfg_data,
    // Input stream.
    input  wire               i_s_tvalid,
    output logic              o_s_tready,
    input  wire  [15:0]       i_s_tdata,   // [4:0] byte_index, [12:5] data_byte, zero fill
    input  wire  [1:0]        i_s_tuser,   // [0] op, [1] channel
    // Output stream.
    output logic              o_m_tvalid,
    input  wire               i_m_tready,
    output logic [15:0]       o_m_tdata,   // [15:0] sample
    output logic [0:0]        o_m_tuser,   // [0] out_channel
    output logic              o_m_tlast    // last
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [6:0] FRAME_LEN = 7'(FRAME_BYTES);
    localparam int OPND_W = adpcm2t_pkg::OPND_W;

    adpcm2t_pkg::t_state   r_state, n_state;
    logic [1:0]            r_step, n_step;
    logic                  r_nib_low, n_nib_low;
    logic [CH_W-1:0]       r_ch;
    logic [7:0]            r_byte;

    logic signed [15:0]    r_coef_first;
    logic signed [15:0]    r_coef_second;
    logic [15:0]           r_scale    [CHANNELS];
    logic signed [15:0]    r_prev_one [CHANNELS];
    logic signed [15:0]    r_prev_two [CHANNELS];

    logic                  r_out_valid;
    logic signed [15:0]    r_out_sample;
    logic                  r_out_channel;
    logic                  r_out_last;

    logic                  w_op;
    logic                  w_chan;
    logic [4:0]            w_idx;
    logic [7:0]            w_byte;
    logic [CH_W-1:0]       w_ch_idx;
    logic                  w_ok;
    logic                  w_busy;
    logic                  w_s_fire;
    logic                  w_clear;
    logic                  w_start;
    logic                  w_emit;
    logic                  w_first_step;
    logic                  w_ch0_zero;
    logic [3:0]            w_nib;
    logic signed [OPND_W-1:0] w_op_a;
    logic signed [OPND_W-1:0] w_op_b;
    logic signed [15:0]    w_sample;
    adpcm2t_pkg::t_mac_ctl w_ctl;

    // Unpack the input transaction.
    always_comb begin
        w_op     = i_s_tuser[0];
        w_chan   = i_s_tuser[1];
        w_idx    = i_s_tdata[4:0];
        w_byte   = i_s_tdata[12:5];
        w_ch_idx = CH_W'(w_chan);
        w_ok     = (int'(w_chan) < CHANNELS) && ({2'b00, w_idx} < FRAME_LEN);
        w_s_fire = i_s_tvalid && o_s_tready;
        w_clear  = w_s_fire && (w_op == adpcm2t_pkg::OP_CLEAR);
        w_start  = w_s_fire && (w_op == adpcm2t_pkg::OP_DATA) && w_ok && (w_idx >= 5'd2);
    end

    // Both channels are ready only out of reset; input also waits for an idle sequencer.
    assign w_busy      = (r_state != adpcm2t_pkg::ST_IDLE);
    assign o_s_tready  = i_rst_n && !w_busy;
    assign o_cfg_ready = i_rst_n;

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= adpcm2t_pkg::ST_IDLE;
            r_step    <= 2'd0;
            r_nib_low <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_nib_low <= n_nib_low;
        end
    end

    // Next state and unit controls: three products, one add, one clip per nibble.
    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        n_nib_low     = r_nib_low;
        w_ctl         = '0;
        w_emit        = 1'b0;
        case (r_state)
            adpcm2t_pkg::ST_IDLE: begin
                if (w_start) begin
                    n_state   = adpcm2t_pkg::ST_MUL;
                    n_step    = 2'd0;
                    n_nib_low = 1'b0;
                end
            end
            adpcm2t_pkg::ST_MUL: begin
                w_ctl.mul_en  = 1'b1;
                w_ctl.shift   = (r_step == 2'd0);
                w_ctl.acc_clr = (r_step == 2'd0);
                w_ctl.acc_add = (r_step != 2'd0);
                if (r_step == 2'd2) begin
                    n_state = adpcm2t_pkg::ST_SUM;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            adpcm2t_pkg::ST_SUM: begin
                w_ctl.acc_add = 1'b1;
                n_state       = adpcm2t_pkg::ST_CLIP;
            end
            adpcm2t_pkg::ST_CLIP: begin
                if (!r_out_valid || i_m_tready) begin
                    w_emit = 1'b1;
                    if (r_nib_low) begin
                        n_state = adpcm2t_pkg::ST_IDLE;
                    end else begin
                        n_state   = adpcm2t_pkg::ST_MUL;
                        n_step    = 2'd0;
                        n_nib_low = 1'b1;
                    end
                end
            end
            default: begin
                n_state = adpcm2t_pkg::ST_IDLE;
            end
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_nib = r_nib_low ? r_byte[3:0] : r_byte[7:4];
        case (r_step)
            2'd0: begin
                w_op_a = {{(OPND_W-4){w_nib[3]}}, w_nib};
                w_op_b = {1'b0, r_scale[r_ch]};
            end
            2'd1: begin
                w_op_a = OPND_W'(r_coef_first);
                w_op_b = OPND_W'(r_prev_one[r_ch]);
            end
            default: begin
                w_op_a = OPND_W'(r_coef_second);
                w_op_b = OPND_W'(r_prev_two[r_ch]);
            end
        endcase
    end

    adpcm2t_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_op_a   (w_op_a),
        .i_op_b   (w_op_b),
        .o_sample (w_sample)
    );

    // Latch the byte being decoded.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_ch   <= w_ch_idx;
            r_byte <= w_byte;
        end
    end

    // Coefficient registers from the configuration channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_first  <= adpcm2t_pkg::COEF_FIRST_RESET;
            r_coef_second <= adpcm2t_pkg::COEF_SECOND_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                adpcm2t_pkg::CFG_COEF_FIRST:  r_coef_first  <= i_cfg_data;
                adpcm2t_pkg::CFG_COEF_SECOND: r_coef_second <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Per-channel scale and sample history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_scale[i]    <= '0;
                r_prev_one[i] <= '0;
                r_prev_two[i] <= '0;
            end
        end else if (w_clear) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_scale[i]    <= '0;
                r_prev_one[i] <= '0;
                r_prev_two[i] <= '0;
            end
        end else if (w_s_fire && w_ok && (w_idx == 5'd0)) begin
            r_scale[w_ch_idx][15:8] <= w_byte;
        end else if (w_s_fire && w_ok && (w_idx == 5'd1)) begin
            r_scale[w_ch_idx][7:0] <= w_byte;
        end else if (w_emit) begin
            r_prev_two[r_ch] <= r_prev_one[r_ch];
            r_prev_one[r_ch] <= w_sample;
        end
    end

    // Output register: filled by the sequencer, emptied by the downstream side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_sample  <= w_sample;
            r_out_channel <= r_ch[0];
            r_out_last    <= r_nib_low;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_sample;
    assign o_m_tuser[0] = r_out_channel;
    assign o_m_tlast    = r_out_last;

    // Conditions watched by the checks below.
    assign w_first_step = (r_state == adpcm2t_pkg::ST_MUL) && (r_step == 2'd0) && !r_nib_low;
    assign w_ch0_zero   = (r_scale[0] == 16'd0) && (r_prev_one[0] == 16'sd0)
                          && (r_prev_two[0] == 16'sd0);

    // A decodable data byte starts the first product step of the high nibble.
    `ADPCM2T_ASSERT_NXT(a_start_mul, i_clk, i_rst_n, w_start, w_first_step)
    // A clear transaction leaves channel zero with no scale and no history.
    `ADPCM2T_ASSERT_NXT(a_clear_zero, i_clk, i_rst_n, w_clear, w_ch0_zero)
    // A sample leaving the clip step lands in the output register with its nibble flag.
    `ADPCM2T_ASSERT_NXT(a_emit_out, i_clk, i_rst_n, w_emit, r_out_valid && (r_out_last == $past(r_nib_low)))
    // The block never takes input while a byte is being decoded.
    `ADPCM2T_ASSERT_IMP(a_busy_stall, i_clk, i_rst_n, w_busy, !w_s_fire)

endmodule

`default_nettype wire
